// ===== rtl/lust_pkg.sv =====
// Shared types, constants and helper functions of the logistic SGD trainer.
package lust_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int SIG_DEPTH    = 1024;
    localparam int ADDR_W       = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int SIG_AW       = $clog2(SIG_DEPTH);

    localparam logic [6:0]  BIAS_ADDR = 7'd64;
    localparam logic [6:0]  MAX_CNT   = 7'(MAX_FEATURES);
    localparam logic [16:0] ONE_Q16   = 17'h10000;

    localparam logic [1:0] KIND_TRAIN = 2'd0;
    localparam logic [1:0] KIND_PRED  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [1:0] RES_PRED   = 2'd0;
    localparam logic [1:0] RES_WEIGHT = 2'd1;
    localparam logic [1:0] RES_ERROR  = 2'd2;

    localparam logic [1:0] REG_LEARN  = 2'd0;
    localparam logic [1:0] REG_DECAY  = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [6:0]         index;
        logic signed [31:0] value;
        logic [16:0]        label;
        logic               last;
    } t_in_req;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [16:0]        prediction;
        logic signed [31:0] weight_value;
    } t_out_rsp;

    typedef struct packed {
        logic [15:0] learn_rate;
        logic [15:0] decay_rate;
        logic [6:0]  feature_count;
    } t_cfg;

    typedef logic [16:0] t_sig_rom [SIG_DEPTH];

    // shift-subtract quotient, only evaluated while the table is built
    function automatic longint unsigned f_udiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            q = q << 1;
            if (r >= d) begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid at bin centers, Q1.31 exp(-u) by Taylor series then squared three times
    function automatic t_sig_rom f_build_rom();
        t_sig_rom          rom;
        longint unsigned   u;
        longint unsigned   term;
        longint            sum;
        longint unsigned   e;
        longint unsigned   d;
        for (int i = 0; i < SIG_DEPTH; i++) begin
            u    = (longint'(2 * i + 1) << 30) >> SIG_AW;
            term = 64'd1 << 31;
            sum  = 64'sd1 <<< 31;
            for (int k = 1; k <= 24; k++) begin
                term = f_udiv64((term * u) >> 31, 64'(k));
                if ((k & 1) == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            e = (sum < 0) ? 64'd0 : longint'(sum);
            for (int k = 0; k < 3; k++) e = (e * e) >> 31;
            d = (64'd1 << 31) + e;
            rom[i] = 17'(f_udiv64((64'd1 << 47) + (d >> 1), d));
        end
        return rom;
    endfunction

    function automatic logic signed [63:0] f_sat_add64(logic signed [63:0] a,
                                                       logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] f_sat32(logic signed [39:0] v);
        if (v > 40'sh007FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -40'sh0080000000) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ===== rtl/lust_ram.sv =====
// Generic single write, single read port RAM with registered read data.
module lust_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/lust_sig.sv =====
// Table sigmoid: bin lookup with registered ROM read, mirror for negative input.
module lust_sig (
    input  logic                i_clk,
    input  logic signed [63:0]  i_z,
    output logic [16:0]         o_p
);
    import lust_pkg::*;

    localparam t_sig_rom SIG_ROM = f_build_rom();
    localparam logic signed [63:0] LIM = 64'sd8 <<< 32;

    logic [63:0]       mag;
    logic [SIG_AW-1:0] idx;
    logic [16:0]       r_data;
    logic              r_neg;
    logic              r_hi;
    logic              r_lo;

    always_comb begin
        mag = i_z[63] ? 64'(-i_z) : 64'(i_z);
        idx = mag[34 -: SIG_AW];
    end

    always_ff @(posedge i_clk) begin
        r_data <= SIG_ROM[idx];
        r_neg  <= i_z[63];
        r_hi   <= i_z >= LIM;
        r_lo   <= i_z <= -LIM;
    end

    assign o_p = r_hi ? ONE_Q16 : r_lo ? 17'd0 : r_neg ? ONE_Q16 - r_data : r_data;
endmodule

// ===== rtl/lust_cfg.sv =====
// APB configuration registers: learn rate, decay rate, feature count.
module lust_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lust_pkg::t_cfg     o_cfg
);
    import lust_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learn_rate    <= 16'd3277;
            r_cfg.decay_rate    <= 16'd7;
            r_cfg.feature_count <= 7'd64;
        end else if (wr) begin
            case (paddr[3:2])
                REG_LEARN: r_cfg.learn_rate    <= pwdata[15:0];
                REG_DECAY: r_cfg.decay_rate    <= pwdata[15:0];
                REG_COUNT: r_cfg.feature_count <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LEARN: prdata = {16'd0, r_cfg.learn_rate};
            REG_DECAY: prdata = {16'd0, r_cfg.decay_rate};
            REG_COUNT: prdata = {25'd0, r_cfg.feature_count};
            default:   prdata = 32'd0;
        endcase
    end
endmodule

// ===== rtl/logistic_unit_sgd_trainer_unit.sv =====
// Top level: sigmoid neuron with streamed inference and online SGD weight update.
//
// Input channel (i_in_valid / o_in_stall, payload t_in_req) takes one request at a
// time. Kind 0/1 requests are feature elements; each is written to the sample RAM
// while its weight is read, multiplied and added to the 64 bit accumulator (IDLE,
// EMUL, EACC). The element flagged last then passes bias add and sigmoid ROM read
// (ZADD, SIGRD) before the prediction is offered; if the element count does not
// match, an error result is offered instead. A training sample then runs the
// update walk: setup (DZ1, DZ2, LDZ), per weight read, multiply and write back
// through the weight RAM port (WRD, WMUL, WWR), then the bias (BIAS), while
// o_in_stall stays high. Kind 2 writes finish on acceptance; kind 3 reads use RDOUT.
// Output channel (o_out_valid / i_out_stall, payload t_out_rsp) is one register;
// while the receiver stalls a result holds, and work that needs no result slot
// keeps going; a new result waits for the slot to empty.
// Reset clears the weight valid bits (weights read as zero), bias, accumulator,
// element count and state, and sets the configuration registers to their defaults;
// no clearing pass is needed. Configuration goes through the APB port at addresses 0, 4 and 8.
module logistic_unit_sgd_trainer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lust_pkg::t_in_req   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lust_pkg::t_out_rsp  o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lust_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EMUL  = 4'd1;
    localparam logic [3:0] S_EACC  = 4'd2;
    localparam logic [3:0] S_ZADD  = 4'd3;
    localparam logic [3:0] S_SIGRD = 4'd4;
    localparam logic [3:0] S_PRED  = 4'd5;
    localparam logic [3:0] S_RDOUT = 4'd6;
    localparam logic [3:0] S_ERR   = 4'd7;
    localparam logic [3:0] S_DZ1   = 4'd8;
    localparam logic [3:0] S_DZ2   = 4'd9;
    localparam logic [3:0] S_LDZ   = 4'd10;
    localparam logic [3:0] S_WRD   = 4'd11;
    localparam logic [3:0] S_WMUL  = 4'd12;
    localparam logic [3:0] S_WWR   = 4'd13;
    localparam logic [3:0] S_BIAS  = 4'd14;

    t_cfg cfg;

    logic [3:0]              r_state;
    t_in_req                 r_item;
    logic [6:0]              r_count;
    logic signed [63:0]      r_acc;
    logic signed [63:0]      r_prod;
    logic signed [63:0]      r_zsum;
    logic signed [63:0]      r_z;
    logic signed [31:0]      r_bias;
    logic [MAX_FEATURES-1:0] r_wvalid;
    logic                    r_rvalid;
    logic [16:0]             r_p;
    logic signed [17:0]      r_diff;
    logic [31:0]             r_s;
    logic signed [31:0]      r_dz;
    logic signed [31:0]      r_ldz;
    logic [31:0]             r_ld;
    logic signed [63:0]      r_pa;
    logic signed [64:0]      r_pb;
    logic signed [31:0]      r_wold;
    logic [6:0]              r_j;
    logic                    r_out_valid;
    t_out_rsp                r_out;

    logic                    in_acc;
    logic                    out_free;
    logic                    emit;
    t_out_rsp                n_out;
    logic [6:0]              fc;
    logic [16:0]             p;
    logic [16:0]             label_c;

    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic [31:0]             w_wdata;
    logic [ADDR_W-1:0]       w_raddr;
    logic [31:0]             w_q;
    logic signed [31:0]      w_rd;
    logic                    s_we;
    logic [31:0]             s_q;

    logic signed [63:0]      acc_sum;
    logic signed [63:0]      z_next;
    logic signed [50:0]      dz_prod;
    logic signed [48:0]      ldz_prod;
    logic signed [64:0]      ra_full;
    logic signed [65:0]      rb_full;
    logic signed [35:0]      step;
    logic signed [31:0]      w_new;
    logic signed [32:0]      bias_step;
    logic signed [31:0]      bias_new;

    lust_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lust_ram #(.DEPTH(MAX_FEATURES), .WIDTH(32)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    lust_ram #(.DEPTH(MAX_FEATURES), .WIDTH(32)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_j[ADDR_W-1:0]),
        .o_rdata (s_q)
    );

    lust_sig u_sig (
        .i_clk (i_clk),
        .i_z   (r_z),
        .o_p   (p)
    );

    assign o_in_stall  = r_state != S_IDLE;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        if (cfg.feature_count == 7'd0) fc = 7'd1;
        else if (cfg.feature_count > MAX_CNT) fc = MAX_CNT;
        else fc = cfg.feature_count;
        label_c = (r_item.label > ONE_Q16) ? ONE_Q16 : r_item.label;
        w_rd    = r_rvalid ? $signed(w_q) : 32'sd0;
    end

    // weight RAM port steering
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_j[ADDR_W-1:0];
        w_wdata = w_new;
        if (in_acc && i_in.kind == KIND_WRITE && i_in.index < MAX_CNT) begin
            w_we    = 1'b1;
            w_waddr = i_in.index[ADDR_W-1:0];
            w_wdata = i_in.value;
        end else if (r_state == S_WWR) begin
            w_we = 1'b1;
        end
        case (r_state)
            S_IDLE:  w_raddr = (i_in.kind == KIND_READ) ? i_in.index[ADDR_W-1:0]
                                                        : r_count[ADDR_W-1:0];
            S_WRD:   w_raddr = r_j[ADDR_W-1:0];
            default: w_raddr = r_item.index[ADDR_W-1:0];
        endcase
        s_we = in_acc && !i_in.kind[1] && r_count < MAX_CNT;
    end

    // arithmetic
    always_comb begin
        acc_sum   = f_sat_add64(r_acc, r_prod);
        z_next    = f_sat_add64(r_zsum, {{16{r_bias[31]}}, r_bias, 16'd0});
        dz_prod   = 51'(r_diff) * $signed({1'b0, r_s});
        ldz_prod  = $signed({1'b0, cfg.learn_rate}) * 49'(r_dz);
        ra_full   = (65'(r_pa) + 65'sd2147483648) >>> 32;
        rb_full   = (66'(r_pb) + 66'sd2147483648) >>> 32;
        step      = 36'(ra_full) + 36'(rb_full);
        w_new     = f_sat32(40'(r_wold) - 40'(step));
        bias_step = 33'((49'(r_ldz) + 49'sd32768) >>> 16);
        bias_new  = f_sat32(40'(r_bias) - 40'(bias_step));
    end

    // result assembly
    always_comb begin
        emit  = 1'b0;
        n_out = '0;
        case (r_state)
            S_PRED: begin
                emit             = out_free;
                n_out.result_kind = RES_PRED;
                n_out.prediction = p;
            end
            S_RDOUT: begin
                emit              = out_free;
                n_out.result_kind = RES_WEIGHT;
                if (r_item.index == BIAS_ADDR) n_out.weight_value = r_bias;
                else if (r_item.index < MAX_CNT) n_out.weight_value = w_rd;
            end
            S_ERR: begin
                emit              = out_free;
                n_out.result_kind = RES_ERROR;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (emit) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        r_rvalid <= r_wvalid[w_raddr];
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= 7'd0;
            r_acc    <= '0;
            r_bias   <= '0;
            r_wvalid <= '0;
            r_j      <= 7'd0;
        end else begin
            if (w_we) r_wvalid[w_waddr] <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item <= i_in;
                        case (i_in.kind)
                            KIND_WRITE: if (i_in.index == BIAS_ADDR) r_bias <= i_in.value;
                            KIND_READ:  r_state <= S_RDOUT;
                            default:    r_state <= S_EMUL;
                        endcase
                    end
                end
                S_EMUL: begin
                    r_prod  <= (r_count < MAX_CNT) ? 64'(w_rd) * 64'(r_item.value) : 64'sd0;
                    r_state <= S_EACC;
                end
                S_EACC: begin
                    if (!r_item.last) begin
                        r_acc <= acc_sum;
                        if (r_count < MAX_CNT) r_count <= r_count + 7'd1;
                        r_state <= S_IDLE;
                    end else begin
                        r_zsum  <= acc_sum;
                        r_acc   <= '0;
                        r_count <= 7'd0;
                        r_state <= ({1'b0, r_count} + 8'd1 != {1'b0, fc}) ? S_ERR : S_ZADD;
                    end
                end
                S_ZADD: begin
                    r_z     <= z_next;
                    r_state <= S_SIGRD;
                end
                S_SIGRD: r_state <= S_PRED;
                S_PRED: begin
                    if (out_free) begin
                        r_p     <= p;
                        r_state <= (r_item.kind == KIND_TRAIN) ? S_DZ1 : S_IDLE;
                    end
                end
                S_RDOUT, S_ERR: if (out_free) r_state <= S_IDLE;
                S_DZ1: begin
                    r_diff  <= $signed({1'b0, r_p}) - $signed({1'b0, label_c});
                    r_s     <= 32'(34'(r_p) * 34'(ONE_Q16 - r_p));
                    r_state <= S_DZ2;
                end
                S_DZ2: begin
                    r_dz    <= 32'((dz_prod + 51'sd32768) >>> 16);
                    r_state <= S_LDZ;
                end
                S_LDZ: begin
                    r_ldz   <= 32'((ldz_prod + 49'sd32768) >>> 16);
                    r_ld    <= cfg.learn_rate * cfg.decay_rate;
                    r_j     <= 7'd0;
                    r_state <= S_WRD;
                end
                S_WRD: r_state <= S_WMUL;
                S_WMUL: begin
                    r_pa    <= 64'(r_ldz) * 64'($signed(s_q));
                    r_pb    <= 65'($signed({1'b0, r_ld})) * 65'(w_rd);
                    r_wold  <= w_rd;
                    r_state <= S_WWR;
                end
                S_WWR: begin
                    r_j     <= r_j + 7'd1;
                    r_state <= (r_j + 7'd1 == fc) ? S_BIAS : S_WRD;
                end
                S_BIAS: begin
                    r_bias  <= bias_new;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/lust_sva.sv =====
// Port-level checker for the trainer, bound to the top level.
module lust_sva (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input lust_pkg::t_in_req  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lust_pkg::t_out_rsp o_out
);
    import lust_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // the input stalls in the cycle after any accepted request other than a write
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.kind != KIND_WRITE |=> o_in_stall)
        else $error("request accepted back to back");

    // unused result fields are zero
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.result_kind == RES_PRED && o_out.weight_value == 0)
                     || (o_out.result_kind == RES_WEIGHT && o_out.prediction == 0)
                     || (o_out.result_kind == RES_ERROR && o_out.weight_value == 0
                         && o_out.prediction == 0))
        else $error("bad result fields");

    a_pred_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.prediction <= ONE_Q16)
        else $error("prediction above one");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind logistic_unit_sgd_trainer_unit lust_sva u_lust_sva (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== verif/testbench.sv =====
// Testbench for the logistic SGD trainer: directed table plus random requests, checked by a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lust_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_req     i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_rsp    o_out;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logistic_unit_sgd_trainer_unit DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [16:0]        sig_tab [SIG_DEPTH];
    logic [15:0]        lr_q, l2_q;
    logic [6:0]         fcnt_q;
    logic signed [31:0] wt [MAX_FEATURES];
    logic signed [31:0] bias_q;
    logic signed [31:0] xbuf [MAX_FEATURES];
    logic signed [63:0] dot_q;
    int                 ecount;
    t_out_rsp           rsp_q [$];
    int                 errors = 0;

    function automatic longint rshift_rnd(longint v, int n);
        longint t;
        t = v + (longint'(1) <<< (n - 1));
        return t >>> n;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return 32'(v);
    endfunction

    function automatic logic signed [63:0] add_sat(longint a, longint b);
        if (b > 0 && a > 64'sh7FFFFFFFFFFFFFFF - b) return 64'sh7FFFFFFFFFFFFFFF;
        if (b < 0 && a < $signed(64'h8000000000000000) - b) return 64'sh8000000000000000;
        return a + b;
    endfunction

    function automatic logic [16:0] sigmoid_of(longint z);
        longint lim;
        longint unsigned a, ix;
        lim = longint'(8) <<< 32;
        if (z >= lim) return ONE_Q16;
        if (z <= -lim) return 17'd0;
        a = (z < 0) ? -z : z;
        ix = (a * SIG_DEPTH) >> 35;
        if (ix >= SIG_DEPTH) ix = SIG_DEPTH - 1;
        return (z < 0) ? ONE_Q16 - sig_tab[ix] : sig_tab[ix];
    endfunction

    task automatic build_sig_tab();
        longint unsigned u, term, e, d;
        longint sum;
        for (int i = 0; i < SIG_DEPTH; i++) begin
            u = (longint'(2 * i + 1) << 30) / SIG_DEPTH;
            term = 64'd1 << 31;
            sum = longint'(1) <<< 31;
            for (int k = 1; k <= 24; k++) begin
                term = ((term * u) >> 31) / k;
                if (k % 2 == 1) sum -= longint'(term);
                else sum += longint'(term);
            end
            e = (sum < 0) ? 0 : sum;
            for (int k = 0; k < 3; k++) e = (e * e) >> 31;
            d = (64'd1 << 31) + e;
            sig_tab[i] = 17'(((64'd1 << 47) + d / 2) / d);
        end
    endtask

    function automatic void sgd_update(logic [16:0] p, logic [16:0] lab, int fc);
        longint dz, ldz, ld, stp;
        dz = rshift_rnd((longint'(p) - longint'(lab)) * (longint'(p) * (65536 - longint'(p))), 16);
        ldz = rshift_rnd(longint'(lr_q) * dz, 16);
        ld = longint'(lr_q) * longint'(l2_q);
        for (int j = 0; j < fc; j++) begin
            stp = rshift_rnd(ldz * longint'(xbuf[j]), 32) + rshift_rnd(ld * longint'(wt[j]), 32);
            wt[j] = clip32(longint'(wt[j]) - stp);
        end
        bias_q = clip32(longint'(bias_q) - rshift_rnd(ldz, 16));
    endfunction

    // returns 1 and fills r when the request yields a result
    function automatic bit predict_request(t_in_req q, output t_out_rsp r);
        logic [16:0] lab, p;
        int fc, pos;
        longint acc;
        r = '0;
        lab = (q.label > ONE_Q16) ? ONE_Q16 : q.label;
        if (q.kind == KIND_WRITE) begin
            if (q.index == BIAS_ADDR) bias_q = q.value;
            else if (q.index < MAX_FEATURES) wt[q.index] = q.value;
            return 0;
        end
        if (q.kind == KIND_READ) begin
            r.result_kind = RES_WEIGHT;
            if (q.index == BIAS_ADDR) r.weight_value = bias_q;
            else if (q.index < MAX_FEATURES) r.weight_value = wt[q.index];
            return 1;
        end
        pos = ecount;
        if (pos < MAX_FEATURES) begin
            xbuf[pos] = q.value;
            dot_q = add_sat(dot_q, longint'(wt[pos]) * longint'(q.value));
        end
        if (!q.last) begin
            if (ecount < MAX_FEATURES) ecount++;
            return 0;
        end
        fc = (fcnt_q == 0) ? 1 : (fcnt_q > MAX_FEATURES) ? MAX_FEATURES : fcnt_q;
        acc = dot_q;
        dot_q = 0;
        ecount = 0;
        if (pos + 1 != fc) begin
            r.result_kind = RES_ERROR;
            return 1;
        end
        p = sigmoid_of(add_sat(acc, longint'(bias_q) * 65536));
        r.result_kind = RES_PRED;
        r.prediction = p;
        if (q.kind == KIND_TRAIN) sgd_update(p, lab, fc);
        return 1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic reg_write(logic [1:0] regi, logic [31:0] v);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = 4'(regi) << 2; pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (regi)
            REG_LEARN: lr_q = v[15:0];
            REG_DECAY: l2_q = v[15:0];
            default:   fcnt_q = v[6:0];
        endcase
    endtask

    task automatic send_request(t_in_req q);
        t_out_rsp r;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in = q;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (predict_request(q, r)) rsp_q.insert(rsp_q.size(), r);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // wait until idle before touching registers
    task automatic drain();
        int n;
        drop_valid();
        n = 0;
        while (rsp_q.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (3 * MAX_FEATURES + 20) @(posedge i_clk);
    endtask

    // receiver: stall pattern redrawn per result
    initial begin : rx_stall
        int s;
        forever begin
            s = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
            @(negedge i_clk);
            i_out_stall = (s > 0);
            repeat (s) @(negedge i_clk);
            i_out_stall = 1'b0;
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rsp_q.size() == 0) begin
                report_mismatch("unexpected result kind", o_out.result_kind, -1);
            end else begin
                want = rsp_q.pop_front();
                if (o_out.result_kind !== want.result_kind)
                    report_mismatch("result_kind", o_out.result_kind, want.result_kind);
                if (o_out.prediction !== want.prediction)
                    report_mismatch("prediction", o_out.prediction, want.prediction);
                if (o_out.weight_value !== want.weight_value)
                    report_mismatch("weight_value", o_out.weight_value, want.weight_value);
            end
        end
    end

    function automatic t_in_req mk(logic [1:0] k, logic [6:0] ix, logic [31:0] v,
                                   logic [16:0] lb, logic l);
        t_in_req q;
        q.kind = k; q.index = ix; q.value = v; q.label = lb; q.last = l;
        return q;
    endfunction

    // one sample of n elements; well formed when n matches the count
    task automatic send_sample(int n, logic [1:0] k, bit wide);
        logic [31:0] v;
        logic [16:0] lb;
        for (int i = 0; i < n; i++) begin
            v = wide ? $urandom : 32'($signed($urandom_range(0, 262143)) - 131072);
            lb = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
            send_request(mk(k, 7'($urandom), v, lb, i == n - 1));
        end
    endtask

    typedef struct {
        t_in_req  q;
        bit       chk;
        t_out_rsp r;
    } t_row;

    t_row rows [$];

    task automatic add_row(t_in_req q, bit chk, t_out_rsp r);
        t_row w;
        w.q = q; w.chk = chk; w.r = r;
        rows.insert(rows.size(), w);
    endtask

    initial begin : main
        t_out_rsp r;
        int fc, n, len;
        build_sig_tab();
        lr_q = 16'd3277; l2_q = 16'd7; fcnt_q = 7'd64;
        foreach (wt[j]) wt[j] = 0;
        bias_q = 0; dot_q = 0; ecount = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset values, extremes, bad address, mismatch, both sample kinds
        reg_write(REG_COUNT, 32'd2);
        add_row(mk(KIND_READ, 7'd0, 0, 0, 0), 1'b1, '{RES_WEIGHT, 17'd0, 32'sd0});
        add_row(mk(KIND_READ, BIAS_ADDR, 0, 0, 1), 1'b1, '{RES_WEIGHT, 17'd0, 32'sd0});
        add_row(mk(KIND_WRITE, 7'd0, 32'h7FFFFFFF, 17'h1FFFF, 1), 1'b0, '0);
        add_row(mk(KIND_READ, 7'd0, 0, 0, 0), 1'b1, '{RES_WEIGHT, 17'd0, 32'sh7FFFFFFF});
        add_row(mk(KIND_WRITE, 7'd63, 32'h80000000, 0, 0), 1'b0, '0);
        add_row(mk(KIND_READ, 7'd63, 0, 0, 0), 1'b1, '{RES_WEIGHT, 17'd0, 32'sh80000000});
        add_row(mk(KIND_WRITE, 7'd100, 32'h12345678, 0, 0), 1'b0, '0);
        add_row(mk(KIND_READ, 7'd127, 0, 0, 0), 1'b1, '{RES_WEIGHT, 17'd0, 32'sd0});
        add_row(mk(KIND_WRITE, BIAS_ADDR, 32'h00080000, 0, 0), 1'b0, '0);
        // z well above 8 saturates to one
        add_row(mk(KIND_PRED, 7'd5, 32'h7FFFFFFF, 0, 0), 1'b0, '0);
        add_row(mk(KIND_PRED, 7'd9, 32'h00000000, 0, 1), 1'b1, '{RES_PRED, ONE_Q16, 32'sd0});
        // one element short
        add_row(mk(KIND_TRAIN, 7'd0, 32'h00010000, 0, 1), 1'b1, '{RES_ERROR, 17'd0, 32'sd0});
        add_row(mk(KIND_WRITE, BIAS_ADDR, 32'hFFF80000, 0, 0), 1'b0, '0);
        add_row(mk(KIND_PRED, 7'd0, 32'h80000000, 0, 0), 1'b0, '0);
        add_row(mk(KIND_READ, 7'd1, 0, 0, 0), 1'b0, '0);
        add_row(mk(KIND_PRED, 7'd0, 32'h00010000, 0, 1), 1'b0, '0);
        add_row(mk(KIND_TRAIN, 7'd0, 32'h00010000, 17'h1FFFF, 0), 1'b0, '0);
        add_row(mk(KIND_TRAIN, 7'd0, 32'hFFFF0000, 17'd0, 1), 1'b0, '0);
        add_row(mk(KIND_PRED, 7'd0, 32'h00001000, 0, 0), 1'b0, '0);
        add_row(mk(KIND_TRAIN, 7'd0, 32'h00002000, 17'h10000, 1), 1'b0, '0);
        add_row(mk(KIND_READ, 7'd0, 0, 0, 0), 1'b0, '0);
        add_row(mk(KIND_READ, BIAS_ADDR, 0, 0, 0), 1'b0, '0);
        foreach (rows[i]) begin
            if (rows[i].chk) begin
                send_request(rows[i].q);
                r = rsp_q.pop_back();
                if (r != rows[i].r)
                    report_mismatch($sformatf("directed row %0d predictor", i),
                                    longint'(r), longint'(rows[i].r));
                rsp_q.insert(rsp_q.size(), rows[i].r);
            end else begin
                send_request(rows[i].q);
            end
        end
        // too many elements
        send_sample(MAX_FEATURES + 3, KIND_TRAIN, 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin reg_write(REG_LEARN, 32'hFFFF); reg_write(REG_DECAY, 32'hFFFF);
                         reg_write(REG_COUNT, 32'd1); end
                1: begin reg_write(REG_LEARN, 0); reg_write(REG_DECAY, 0);
                         reg_write(REG_COUNT, 32'd0); end
                2: begin reg_write(REG_COUNT, 32'd127); reg_write(REG_LEARN, 32'd3277); end
                default: begin
                    reg_write(REG_LEARN, $urandom);
                    reg_write(REG_DECAY, $urandom_range(0, 3) == 0 ? 0 : $urandom);
                    reg_write(REG_COUNT, (ph == 7) ? 32'd64 : $urandom_range(1, 8));
                end
            endcase
            fc = (fcnt_q == 0) ? 1 : (fcnt_q > MAX_FEATURES) ? MAX_FEATURES : fcnt_q;
            n = 0;
            while (n < ((ph == 2 || ph == 7) ? 130 : 170)) begin
                case ($urandom_range(0, 9))
                    0: begin send_request(mk(KIND_WRITE, 7'($urandom), $urandom, 17'($urandom),
                                             1'($urandom))); n++; end
                    1: begin send_request(mk(KIND_READ, $urandom_range(0, 3) == 0 ?
                                             7'($urandom) : 7'($urandom_range(0, 64)), $urandom,
                                             17'($urandom), 1'($urandom))); n++; end
                    2: begin len = $urandom_range(1, fc + 2);
                             send_sample(len, 2'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1))); n += len; end
                    default: begin send_sample(fc, 2'($urandom_range(0, 1)),
                                               $urandom_range(0, 3) == 0); n += fc; end
                endcase
            end
            drain();
        end
        if (errors == 0 && rsp_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (rsp_q.size() != 0)
                $display("ERROR %0d results never arrived", rsp_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
